// ===== design/vocg_pkg.sv =====
package vocg_pkg;

    // one input item: operation and a point in signed Q16.8
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic blocked;
        logic range_error;
    } t_out_item;

    // per-axis in-box flags for the offsets -1, 0, +1 (bit 1 is the centre voxel)
    typedef struct packed {
        logic [2:0] x;
        logic [2:0] y;
        logic [2:0] z;
    } t_axis_ok;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] CFG_CELL_RECIPROCAL = 2'd0;
    localparam logic [1:0] CFG_X_HALF_CELLS    = 2'd1;
    localparam logic [1:0] CFG_Y_HALF_CELLS    = 2'd2;
    localparam logic [1:0] CFG_Z_DEPTH_CELLS   = 2'd3;

    localparam logic [15:0] RST_CELL_RECIPROCAL = 16'd256;
    localparam logic [4:0]  RST_X_HALF_CELLS    = 5'd31;
    localparam logic [4:0]  RST_Y_HALF_CELLS    = 5'd31;
    localparam logic [5:0]  RST_Z_DEPTH_CELLS   = 6'd63;

    // one voxel in Q.16
    localparam logic signed [41:0] Q16_ONE  = 42'sd65536;
    localparam logic [41:0]        Q16_HALF = 42'd32768;

    // round a Q.16 value to an integer, halves away from zero
    function automatic logic signed [24:0] round_q16(input logic signed [41:0] v);
        logic [41:0] mag;
        logic [41:0] sum;
        logic [24:0] r;
        mag = v[41] ? 42'(-v) : 42'(v);
        sum = mag + Q16_HALF;
        r   = sum[40:16];
        return v[41] ? $signed(25'(-r)) : $signed(r);
    endfunction

endpackage

// ===== design/vocg_quant.sv =====
module vocg_quant #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64,
    parameter int GRID_Z = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [23:0]     i_pos_x,
    input  logic signed [23:0]     i_pos_y,
    input  logic signed [23:0]     i_pos_z,
    input  logic [15:0]            i_recip,
    input  logic [4:0]             i_x_half,
    input  logic [4:0]             i_y_half,
    input  logic [5:0]             i_z_depth,
    output logic                   o_valid,
    output vocg_pkg::t_axis_ok     o_ok,
    output logic [$clog2(GRID_X)-1:0] o_ax [3],
    output logic [$clog2(GRID_Y)-1:0] o_ay [3],
    output logic [$clog2(GRID_Z)-1:0] o_az [3]
);
    import vocg_pkg::*;

    localparam int XW = $clog2(GRID_X);
    localparam int YW = $clog2(GRID_Y);
    localparam int ZW = $clog2(GRID_Z);

    localparam logic signed [25:0] LIM_X = 26'(GRID_X);
    localparam logic signed [25:0] LIM_Y = 26'(GRID_Y);
    localparam logic signed [25:0] LIM_Z = 26'(GRID_Z);

    logic r_v1, r_v2, r_v3;
    logic signed [40:0] r_px, r_py, r_pz;
    logic signed [24:0] r_ix [3];
    logic signed [24:0] r_iy [3];
    logic signed [24:0] r_iz [3];

    logic signed [41:0] off [3];
    assign off[0] = -Q16_ONE;
    assign off[1] = '0;
    assign off[2] = Q16_ONE;

    logic signed [25:0] sum_x [3];
    logic signed [25:0] sum_y [3];
    logic signed [25:0] sum_z [3];
    logic signed [25:0] hx, hy, hz;

    assign hx = $signed(26'(i_x_half));
    assign hy = $signed(26'(i_y_half));
    assign hz = $signed(26'(i_z_depth));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_x[k] = 26'(r_ix[k]) + hx;
            sum_y[k] = 26'(r_iy[k]) + hy;
            sum_z[k] = 26'(r_iz[k]) + hz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // scale by the reciprocal cell size
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_px <= i_pos_x * $signed({1'b0, i_recip});
            r_py <= i_pos_y * $signed({1'b0, i_recip});
            r_pz <= i_pos_z * $signed({1'b0, i_recip});
        end
    end

    // round each neighbour offset on its own; ties make it differ from index plus one
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int k = 0; k < 3; k++) begin
                r_ix[k] <= round_q16(42'(r_px) + off[k]);
                r_iy[k] <= round_q16(42'(r_py) + off[k]);
                r_iz[k] <= round_q16(42'(r_pz) + off[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            for (int k = 0; k < 3; k++) begin
                o_ok.x[k] <= (sum_x[k] >= 0) && (26'(r_ix[k]) <= hx) && (sum_x[k] < LIM_X);
                o_ok.y[k] <= (sum_y[k] >= 0) && (26'(r_iy[k]) <= hy) && (sum_y[k] < LIM_Y);
                o_ok.z[k] <= (sum_z[k] >= 0) && (r_iz[k] <= 0) && (sum_z[k] < LIM_Z);
                o_ax[k]   <= sum_x[k][XW-1:0];
                o_ay[k]   <= sum_y[k][YW-1:0];
                o_az[k]   <= sum_z[k][ZW-1:0];
            end
        end
    end

    assign o_valid = r_v3;

endmodule

// ===== design/voxel_occupancy_collision_grid_top.sv =====
// Voxel occupancy grid with a 27-voxel neighbourhood collision check.
//
// Input: an item (operation and a Q16.8 point) is taken at a rising edge with
// start high and busy low. busy stays high until the result has been issued.
// Output: one result per item, on o_result for a single cycle with o_valid
// high. The receiver cannot stall, so results are never held back.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one register a cycle;
// write only while busy is low.
//
// Sequence: quantisation registers the multiply, the round and the range check in turn, then
//   check      : 9 row steps, reads skipped for rows outside the box, then a drain step
//   mark/clear : one read and one write back
//   mark/clear out of box (range_error) or unknown operation: no memory access
// The next item may start in the cycle the result is shown. The bitmap is
// stored as GRID_X*GRID_Y rows of GRID_Z bits in one single-port memory; its
// one access per cycle sets the check time.
// Reset: control and configuration registers take their reset values and a
// clearing pass zeroes the bitmap's GRID_X*GRID_Y rows (4096 by default), one row a
// cycle, with busy high throughout. Configuration writes are taken during the pass.
module voxel_occupancy_collision_grid_top #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64,
    parameter int GRID_Z = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  vocg_pkg::t_in_item   i_item,
    output logic                 o_valid,
    output vocg_pkg::t_out_item  o_result,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);
    import vocg_pkg::*;

    localparam int XW   = $clog2(GRID_X);
    localparam int YW   = $clog2(GRID_Y);
    localparam int ZW   = $clog2(GRID_Z);
    localparam int ROWS = GRID_X * GRID_Y;
    localparam int RW   = $clog2(ROWS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_QUANT = 6'b000100,
        S_CHECK = 6'b001000,
        S_DRAIN = 6'b010000,
        S_WRITE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_recip;
    logic [4:0]  r_x_half, r_y_half;
    logic [5:0]  r_z_depth;
    logic [1:0]  r_op;
    logic [RW-1:0] r_clr, n_clr;
    logic [1:0]  r_ci, n_ci, r_cj, n_cj;
    logic        r_blk, n_blk;
    logic        r_rd_v, r_rd_ok;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic        q_valid;
    t_axis_ok    q_ok;
    logic [XW-1:0] q_ax [3];
    logic [YW-1:0] q_ay [3];
    logic [ZW-1:0] q_az [3];

    logic              accept;
    logic              mem_we, mem_re;
    logic [RW-1:0]     mem_addr;
    logic [GRID_Z-1:0] mem_wdata;
    logic [GRID_Z-1:0] r_rdata;
    logic [GRID_Z-1:0] mem [ROWS];

    logic [XW-1:0] sel_ax;
    logic [YW-1:0] sel_ay;
    logic          sel_ok;
    logic          row_hit;
    logic          centre_ok;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE) || !i_rst_n;

    vocg_quant #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_quant (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_pos_x   (i_item.pos_x),
        .i_pos_y   (i_item.pos_y),
        .i_pos_z   (i_item.pos_z),
        .i_recip   (r_recip),
        .i_x_half  (r_x_half),
        .i_y_half  (r_y_half),
        .i_z_depth (r_z_depth),
        .o_valid   (q_valid),
        .o_ok      (q_ok),
        .o_ax      (q_ax),
        .o_ay      (q_ay),
        .o_az      (q_az)
    );

    // row of the current neighbour during a check, else the centre row
    always_comb begin
        if (r_state == S_CHECK) begin
            sel_ax = q_ax[r_ci];
            sel_ay = q_ay[r_cj];
            sel_ok = q_ok.x[r_ci] && q_ok.y[r_cj];
        end else begin
            sel_ax = q_ax[1];
            sel_ay = q_ay[1];
            sel_ok = q_ok.x[1] && q_ok.y[1];
        end
    end

    assign centre_ok = q_ok.x[1] && q_ok.y[1] && q_ok.z[1];

    // blocked contribution of the row read last cycle
    always_comb begin
        row_hit = !r_rd_ok;
        for (int k = 0; k < 3; k++) begin
            row_hit = row_hit || !q_ok.z[k] || r_rdata[q_az[k]];
        end
    end

    always_comb begin
        mem_addr  = RW'(sel_ax) * RW'(GRID_Y) + RW'(sel_ay);
        mem_wdata = r_rdata;
        mem_wdata[q_az[1]] = (r_op == OP_MARK);
        if (r_state == S_CLEAR) begin
            mem_addr  = r_clr;
            mem_wdata = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_ci        = r_ci;
        n_cj        = r_cj;
        n_blk       = r_blk;
        n_out_valid = 1'b0;
        n_out       = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (r_rd_v) begin
            n_blk = r_blk || row_hit;
        end
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (r_clr == RW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_QUANT;
                end
            end
            S_QUANT: begin
                if (q_valid) begin
                    case (r_op)
                        OP_CHECK: begin
                            n_ci    = 2'd0;
                            n_cj    = 2'd0;
                            n_blk   = 1'b0;
                            n_state = S_CHECK;
                        end
                        OP_MARK, OP_CLEAR: begin
                            if (centre_ok) begin
                                mem_re  = 1'b1;
                                n_state = S_WRITE;
                            end else begin
                                n_out_valid       = 1'b1;
                                n_out.range_error = 1'b1;
                                n_state           = S_IDLE;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                // skip the read of a row that lies outside the box
                mem_re = sel_ok;
                if (r_cj == 2'd2) begin
                    n_cj = 2'd0;
                    n_ci = r_ci + 1'b1;
                    if (r_ci == 2'd2) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_cj = r_cj + 1'b1;
                end
            end
            S_DRAIN: begin
                n_out_valid   = 1'b1;
                n_out.blocked = r_blk || row_hit;
                n_state       = S_IDLE;
            end
            S_WRITE: begin
                mem_we      = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ci        <= 2'd0;
            r_cj        <= 2'd0;
            r_blk       <= 1'b0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_recip     <= RST_CELL_RECIPROCAL;
            r_x_half    <= RST_X_HALF_CELLS;
            r_y_half    <= RST_Y_HALF_CELLS;
            r_z_depth   <= RST_Z_DEPTH_CELLS;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ci        <= n_ci;
            r_cj        <= n_cj;
            r_blk       <= n_blk;
            r_rd_v      <= (r_state == S_CHECK);
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CELL_RECIPROCAL: r_recip   <= i_cfg_data;
                    CFG_X_HALF_CELLS:    r_x_half  <= i_cfg_data[4:0];
                    CFG_Y_HALF_CELLS:    r_y_half  <= i_cfg_data[4:0];
                    CFG_Z_DEPTH_CELLS:   r_z_depth <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= sel_ok;
        r_out   <= n_out;
        if (accept) begin
            r_op <= i_item.operation;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_no_result_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_valid)
        else $error("result issued right after an item was taken");

    a_mem_single_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("memory read and written in the same cycle");

    a_fields_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.blocked && o_result.range_error))
        else $error("blocked and range error raised together");

endmodule
